@@ rtl/hgsg_pkg.sv @@
// ----------------------------------------------------------------------------
// hgsg_pkg: shared types and constants of the hold gate
// widths, register codes, reset values and state encodings
// ----------------------------------------------------------------------------
package hgsg_pkg;

	localparam int SAMPLE_W = 24;
	localparam int COEFF_W  = 25;
	localparam int HOLD_W   = 18;
	localparam int GROW_W   = 16;
	localparam int ACT_W    = 22;
	localparam int MUL_W    = 27;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int FRAC_W   = 24;
	localparam int IDX_W    = 4;
	localparam int IN_W     = 96;
	localparam int OUT_W    = 80;

	localparam logic [COEFF_W-1:0] ONE_Q24 = 25'd16777216;

	localparam int unsigned OPEN_COEFF_DEF = 58151;

	localparam logic [COEFF_W-1:0] RST_ATTACK    = 25'd1156000;
	localparam logic [COEFF_W-1:0] RST_RELEASE   = 25'd4369;
	localparam logic [COEFF_W-1:0] RST_THRESHOLD = 25'd16777;
	localparam logic [COEFF_W-1:0] RST_FLOOR     = 25'd0;
	localparam logic [COEFF_W-1:0] RST_CLOSE     = 25'd34900;
	localparam logic [HOLD_W-1:0]  RST_HOLD_BASE = 18'd4800;
	localparam logic [HOLD_W-1:0]  RST_HOLD_MAX  = 18'd96000;
	localparam logic [GROW_W-1:0]  RST_GROWTH    = 16'd0;

	typedef enum logic [IDX_W-1:0] {
		REG_ATTACK    = 4'd0,
		REG_RELEASE   = 4'd1,
		REG_THRESHOLD = 4'd2,
		REG_FLOOR     = 4'd3,
		REG_CLOSE     = 4'd4,
		REG_HOLD_BASE = 4'd5,
		REG_HOLD_MAX  = 4'd6,
		REG_GROWTH    = 4'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_OPEN    = 2'd1,
		MODE_HOLD    = 2'd2,
		MODE_CLOSING = 2'd3
	} gate_mode_t;

	typedef enum logic [3:0] {
		SEQ_IDLE,
		SEQ_ENV_MUL,
		SEQ_ENV_UPD,
		SEQ_ACT,
		SEQ_GROW_MUL,
		SEQ_GATE,
		SEQ_GAIN_MUL,
		SEQ_GAIN_UPD,
		SEQ_WL_MUL,
		SEQ_WR_MUL,
		SEQ_DONE
	} seq_state_t;

	// effective settings after saturation and hold limits
	typedef struct packed {
		logic [COEFF_W-1:0] attack;
		logic [COEFF_W-1:0] release_c;
		logic [COEFF_W-1:0] threshold;
		logic [COEFF_W-1:0] floor_lvl;
		logic [COEFF_W-1:0] close_c;
		logic [HOLD_W-1:0]  base;
		logic [HOLD_W-1:0]  hmax;
		logic [GROW_W-1:0]  growth;
	} cfg_t;

	function automatic logic [COEFF_W-1:0] sat_one(input logic [COEFF_W-1:0] c);
		return (c > ONE_Q24) ? ONE_Q24 : c;
	endfunction

endpackage

@@ rtl/hgsg_mul.sv @@
// ----------------------------------------------------------------------------
// hgsg_mul: shared signed multiplier
// one registered signed product per cycle, reused by every product step
// ----------------------------------------------------------------------------
module hgsg_mul (
	input  logic                                 clk,
	input  logic signed [hgsg_pkg::MUL_W-1:0]    a,
	input  logic signed [hgsg_pkg::MUL_W-1:0]    b,
	output logic signed [hgsg_pkg::PROD_W-1:0]   p
);

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

@@ rtl/hgsg_cfg.sv @@
// ----------------------------------------------------------------------------
// hgsg_cfg: configuration registers
// write-only register file; presents saturated and limited settings
// ----------------------------------------------------------------------------
module hgsg_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [hgsg_pkg::IDX_W-1:0]         cfg_index,
	input  logic [hgsg_pkg::COEFF_W-1:0]       cfg_data,
	output hgsg_pkg::cfg_t                     cfg
);

	logic [hgsg_pkg::COEFF_W-1:0] attack_q, release_q, threshold_q, floor_q, close_q;
	logic [hgsg_pkg::HOLD_W-1:0]  base_q, hmax_q;
	logic [hgsg_pkg::GROW_W-1:0]  growth_q;
	logic [hgsg_pkg::HOLD_W-1:0]  base_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q    <= hgsg_pkg::RST_ATTACK;
			release_q   <= hgsg_pkg::RST_RELEASE;
			threshold_q <= hgsg_pkg::RST_THRESHOLD;
			floor_q     <= hgsg_pkg::RST_FLOOR;
			close_q     <= hgsg_pkg::RST_CLOSE;
			base_q      <= hgsg_pkg::RST_HOLD_BASE;
			hmax_q      <= hgsg_pkg::RST_HOLD_MAX;
			growth_q    <= hgsg_pkg::RST_GROWTH;
		end else if (cfg_we) begin
			case (cfg_index)
				hgsg_pkg::REG_ATTACK:    attack_q    <= cfg_data;
				hgsg_pkg::REG_RELEASE:   release_q   <= cfg_data;
				hgsg_pkg::REG_THRESHOLD: threshold_q <= cfg_data;
				hgsg_pkg::REG_FLOOR:     floor_q     <= cfg_data;
				hgsg_pkg::REG_CLOSE:     close_q     <= cfg_data;
				hgsg_pkg::REG_HOLD_BASE: base_q      <= cfg_data[hgsg_pkg::HOLD_W-1:0];
				hgsg_pkg::REG_HOLD_MAX:  hmax_q      <= cfg_data[hgsg_pkg::HOLD_W-1:0];
				hgsg_pkg::REG_GROWTH:    growth_q    <= cfg_data[hgsg_pkg::GROW_W-1:0];
				default: ;
			endcase
		end
	end

	// zero base acts as one, max below base acts as base
	assign base_eff = (base_q == '0) ? hgsg_pkg::HOLD_W'(1) : base_q;

	always_comb begin
		cfg.attack    = hgsg_pkg::sat_one(attack_q);
		cfg.release_c = hgsg_pkg::sat_one(release_q);
		cfg.threshold = threshold_q;
		cfg.floor_lvl = hgsg_pkg::sat_one(floor_q);
		cfg.close_c   = hgsg_pkg::sat_one(close_q);
		cfg.base      = base_eff;
		cfg.hmax      = (hmax_q < base_eff) ? base_eff : hmax_q;
		cfg.growth    = growth_q;
	end

endmodule

@@ rtl/hold_gate_with_slewed_gain_unit.sv @@
// ----------------------------------------------------------------------------
// hold_gate_with_slewed_gain_unit: keyed noise gate with retriggerable hold
// envelope follower, four-state gate and slewed gain on a stereo wet signal
// ----------------------------------------------------------------------------
// Each input transfer carries a dry key pair and a wet pair; each one gives
// exactly one output transfer with both gated wet samples, the gain used and
// the gate mode. An item runs through every sequencer step before its result
// is loaded into the output register, and the input reopens after that load;
// a small sequencer runs five products (envelope slew, hold growth, gain
// slew, left and right gain) one after another through a single registered
// 27x27 signed multiplier, with update steps in between.
// The input is not ready while an item is in work. A finished result waits
// in the output register, so the next item is accepted while it is still
// pending; the sequencer only waits at its last step if the previous result
// has not been taken. Configuration writes take effect at once and belong
// between items.
// ----------------------------------------------------------------------------
module hold_gate_with_slewed_gain_unit #(
	parameter int unsigned OPEN_COEFF = hgsg_pkg::OPEN_COEFF_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// dry_left[23:0], dry_right[47:24], wet_left[71:48], wet_right[95:72]
	input  logic [hgsg_pkg::IN_W-1:0]         s_axis_tdata,
	// output stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// gated_left[23:0], gated_right[47:24], applied_gain[72:48],
	// gate_status[74:73], zero[79:75]
	output logic [hgsg_pkg::OUT_W-1:0]        m_axis_tdata,
	// configuration writes
	input  logic                              cfg_we,
	input  logic [hgsg_pkg::IDX_W-1:0]        cfg_index,
	input  logic [hgsg_pkg::COEFF_W-1:0]      cfg_data
);

	localparam int SW = hgsg_pkg::SAMPLE_W;
	localparam int CW = hgsg_pkg::COEFF_W;
	localparam int MW = hgsg_pkg::MUL_W;
	localparam int PW = hgsg_pkg::PROD_W;
	localparam int FW = hgsg_pkg::FRAC_W;
	localparam int HW = hgsg_pkg::HOLD_W;
	localparam int AW = hgsg_pkg::ACT_W;
	localparam int GW = hgsg_pkg::GROW_W;
	localparam int SHW = PW - FW;          // width of a product after >>> 24
	localparam int EW = HW + 5;            // base plus grown hold

	// rise coefficient of the gain, saturated to one
	localparam logic [CW-1:0] OPEN_SAT =
		(OPEN_COEFF > 32'd16777216) ? hgsg_pkg::ONE_Q24 : CW'(OPEN_COEFF);

	hgsg_pkg::cfg_t        cfg;
	hgsg_pkg::seq_state_t  seq_q, seq_d;
	hgsg_pkg::gate_mode_t  mode_q;

	// block state
	logic [CW-1:0]         env_q;
	logic [CW-1:0]         gain_q;
	logic [HW-1:0]         hold_q;
	logic [AW-1:0]         active_q;
	logic                  present_q;

	// item payload
	logic [CW-1:0]         x_q;
	logic signed [SW-1:0]  wl_q, wr_q;
	logic signed [SW-1:0]  left_q;

	// output register
	logic                  out_valid_q;
	logic signed [SW-1:0]  out_left_q, out_right_q;
	logic [CW-1:0]         out_gain_q;
	logic [1:0]            out_mode_q;

	// shared multiplier
	logic signed [MW-1:0]  mul_a, mul_b;
	logic signed [PW-1:0]  prod;
	logic signed [SHW-1:0] prod_sh;

	logic                  in_xfer;
	logic                  out_load;
	logic [CW-1:0]         abs_l, abs_r;
	logic [CW-1:0]         env_coeff, gain_coeff, gain_target;
	logic signed [SHW-1:0] slew_base, slew_sum;
	logic [CW-1:0]         slew_clamped;
	logic [EW-1:0]         hold_grown;
	logic [HW-1:0]         hold_eff;
	logic [HW-1:0]         hold_dec;

	hgsg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hgsg_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (seq_q == hgsg_pkg::SEQ_IDLE);

	// result leaves once the previous one is gone or going
	assign out_load = (seq_q == hgsg_pkg::SEQ_DONE) && (!out_valid_q || m_axis_tready);

	// |dry_left| + |dry_right|, up to exactly one in Q1.24
	always_comb begin
		logic signed [SW:0] dl, dr;
		dl    = {s_axis_tdata[SW-1], s_axis_tdata[SW-1:0]};
		dr    = {s_axis_tdata[2*SW-1], s_axis_tdata[2*SW-1:SW]};
		abs_l = CW'(dl[SW] ? -dl : dl);
		abs_r = CW'(dr[SW] ? -dr : dr);
	end

	// rise or fall coefficients for the two slews
	assign env_coeff   = (x_q > env_q) ? cfg.attack : cfg.release_c;
	assign gain_target = (mode_q == hgsg_pkg::MODE_OPEN || mode_q == hgsg_pkg::MODE_HOLD)
		? hgsg_pkg::ONE_Q24 : cfg.floor_lvl;
	assign gain_coeff  = (gain_target > gain_q) ? OPEN_SAT : cfg.close_c;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (seq_q)
			hgsg_pkg::SEQ_ENV_MUL: begin
				mul_a = MW'(env_coeff);
				mul_b = $signed(MW'(x_q)) - $signed(MW'(env_q));
			end
			hgsg_pkg::SEQ_GROW_MUL: begin
				mul_a = MW'(cfg.growth);
				mul_b = MW'(active_q);
			end
			hgsg_pkg::SEQ_GAIN_MUL: begin
				mul_a = MW'(gain_coeff);
				mul_b = $signed(MW'(gain_target)) - $signed(MW'(gain_q));
			end
			hgsg_pkg::SEQ_WL_MUL: begin
				mul_a = MW'(wl_q);
				mul_b = MW'(gain_q);
			end
			// the right product is held until the result can leave
			hgsg_pkg::SEQ_WR_MUL, hgsg_pkg::SEQ_DONE: begin
				mul_a = MW'(wr_q);
				mul_b = MW'(gain_q);
			end
			default: ;
		endcase
	end

	// arithmetic shift gives the floored Q24 product
	assign prod_sh = prod[PW-1:FW];

	// level plus floored step, clamped to [0, one]
	assign slew_base = (seq_q == hgsg_pkg::SEQ_ENV_UPD) ? SHW'(env_q) : SHW'(gain_q);
	assign slew_sum  = slew_base + prod_sh;
	always_comb begin
		if (slew_sum < 0)
			slew_clamped = '0;
		else if (slew_sum > $signed(SHW'(hgsg_pkg::ONE_Q24)))
			slew_clamped = hgsg_pkg::ONE_Q24;
		else
			slew_clamped = slew_sum[CW-1:0];
	end

	// effective hold: base plus grown part, limited to the max
	assign hold_grown = EW'(cfg.base) + EW'(prod[AW+GW-1:GW]);
	assign hold_eff   = (hold_grown > EW'(cfg.hmax)) ? cfg.hmax : hold_grown[HW-1:0];
	assign hold_dec   = (hold_q != '0) ? hold_q - HW'(1) : '0;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seq_q <= hgsg_pkg::SEQ_IDLE;
		else
			seq_q <= seq_d;
	end

	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			hgsg_pkg::SEQ_IDLE:     if (in_xfer) seq_d = hgsg_pkg::SEQ_ENV_MUL;
			hgsg_pkg::SEQ_ENV_MUL:  seq_d = hgsg_pkg::SEQ_ENV_UPD;
			hgsg_pkg::SEQ_ENV_UPD:  seq_d = hgsg_pkg::SEQ_ACT;
			hgsg_pkg::SEQ_ACT:      seq_d = hgsg_pkg::SEQ_GROW_MUL;
			hgsg_pkg::SEQ_GROW_MUL: seq_d = hgsg_pkg::SEQ_GATE;
			hgsg_pkg::SEQ_GATE:     seq_d = hgsg_pkg::SEQ_GAIN_MUL;
			hgsg_pkg::SEQ_GAIN_MUL: seq_d = hgsg_pkg::SEQ_GAIN_UPD;
			hgsg_pkg::SEQ_GAIN_UPD: seq_d = hgsg_pkg::SEQ_WL_MUL;
			hgsg_pkg::SEQ_WL_MUL:   seq_d = hgsg_pkg::SEQ_WR_MUL;
			hgsg_pkg::SEQ_WR_MUL:   seq_d = hgsg_pkg::SEQ_DONE;
			hgsg_pkg::SEQ_DONE:     if (out_load) seq_d = hgsg_pkg::SEQ_IDLE;
			default:                seq_d = hgsg_pkg::SEQ_IDLE;
		endcase
	end

	// item payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q  <= abs_l + abs_r;
			wl_q <= s_axis_tdata[3*SW-1:2*SW];
			wr_q <= s_axis_tdata[4*SW-1:3*SW];
		end
		if (seq_q == hgsg_pkg::SEQ_WR_MUL)
			left_q <= prod_sh[SW-1:0];
	end

	// block state updates, one step per sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q     <= '0;
			gain_q    <= '0;
			hold_q    <= '0;
			active_q  <= '0;
			present_q <= 1'b0;
			mode_q    <= hgsg_pkg::MODE_IDLE;
		end else begin
			case (seq_q)
				hgsg_pkg::SEQ_ENV_UPD: env_q <= slew_clamped;
				hgsg_pkg::SEQ_ACT: begin
					present_q <= (env_q > cfg.threshold);
					// active count capped at 16 times the max hold
					if ((env_q > cfg.threshold) && (active_q < {cfg.hmax, 4'b0000}))
						active_q <= active_q + AW'(1);
				end
				hgsg_pkg::SEQ_GATE: begin
					case (mode_q)
						hgsg_pkg::MODE_IDLE, hgsg_pkg::MODE_CLOSING: begin
							if (present_q) begin
								mode_q   <= hgsg_pkg::MODE_OPEN;
								active_q <= AW'(1);
							end
						end
						hgsg_pkg::MODE_OPEN: begin
							if (!present_q) begin
								mode_q <= hgsg_pkg::MODE_HOLD;
								hold_q <= hold_eff;
							end
						end
						default: begin
							// hold: retrigger or count down to closing
							if (present_q) begin
								mode_q <= hgsg_pkg::MODE_OPEN;
							end else begin
								hold_q <= hold_dec;
								if (hold_dec == '0)
									mode_q <= hgsg_pkg::MODE_CLOSING;
							end
						end
					endcase
				end
				hgsg_pkg::SEQ_GAIN_UPD: gain_q <= slew_clamped;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left_q  <= left_q;
			out_right_q <= prod_sh[SW-1:0];
			out_gain_q  <= gain_q;
			out_mode_q  <= mode_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'b00000, out_mode_q, out_gain_q, out_right_q, out_left_q};

	// gain and envelope never leave [0, one]
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		gain_q <= hgsg_pkg::ONE_Q24)
		else $error("gain above one");

	a_env_range: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= hgsg_pkg::ONE_Q24)
		else $error("envelope above one");

	// a hold is always loaded with at least one sample
	a_hold_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == hgsg_pkg::MODE_HOLD) |-> (hold_q != '0))
		else $error("hold mode with empty hold count");

	// an open gate has counted at least one active sample
	a_open_active: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == hgsg_pkg::MODE_OPEN) |-> (active_q != '0))
		else $error("open gate with zero active count");

	// a result is only loaded from the last step and then the input reopens
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (seq_q == hgsg_pkg::SEQ_IDLE) && out_valid_q)
		else $error("result load did not complete the item");

endmodule

@@ verif/tb_hold_gate_with_slewed_gain_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hold_gate_with_slewed_gain_unit: self-checking bench for the hold gate
// streams keyed sample frames through the gate under many register settings,
// predicts envelope, gate mode, hold and gain slew for every accepted frame
// and compares each output transfer field by field in arrival order
// ----------------------------------------------------------------------------
module tb_hold_gate_with_slewed_gain_unit;
	import hgsg_pkg::*;

	localparam int unsigned RISE_COEFF     = OPEN_COEFF_DEF;
	localparam int unsigned WATCHDOG_LIMIT = 1000;
	localparam int unsigned SETTLE_CYCLES  = 16;   // a bit over the latency of one item
	localparam int unsigned STALL_CYCLES   = 64;   // long receiver hold-off
	localparam int unsigned STALL_AFTER    = 400;  // input transfers before the hold-off

	localparam logic [IDX_W-1:0]    UNMAPPED_IDX_LO = 4'd8;
	localparam logic [IDX_W-1:0]    UNMAPPED_IDX_HI = 4'd15;
	localparam logic [COEFF_W-1:0]  ALL_ONES_25     = 25'h1FFFFFF;
	// upper bits set, low 18 bits clear: lands as zero in a hold register
	localparam logic [COEFF_W-1:0]  HOLD_OVERSIZED  = 25'h1FC0000;
	localparam logic [SAMPLE_W-1:0] S_MAX           = 24'h7FFFFF;
	localparam logic [SAMPLE_W-1:0] S_MIN           = 24'h800000;

	// one input transfer, dry_left in the lowest bits
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] wet_right;
		logic signed [SAMPLE_W-1:0] wet_left;
		logic signed [SAMPLE_W-1:0] dry_right;
		logic signed [SAMPLE_W-1:0] dry_left;
	} key_frame_t;

	// one output transfer, gated_left in the lowest bits
	typedef struct packed {
		logic [OUT_W-2*SAMPLE_W-COEFF_W-3:0] pad;
		gate_mode_t                          status;
		logic [COEFF_W-1:0]                  gain;
		logic signed [SAMPLE_W-1:0]          right;
		logic signed [SAMPLE_W-1:0]          left;
	} gated_frame_t;

	// raw register values as written, before any truncation
	typedef struct {
		logic [COEFF_W-1:0] rise;
		logic [COEFF_W-1:0] fall;
		logic [COEFF_W-1:0] thresh;
		logic [COEFF_W-1:0] floor_lvl;
		logic [COEFF_W-1:0] close_c;
		logic [COEFF_W-1:0] hold_base;
		logic [COEFF_W-1:0] hold_max;
		logic [COEFF_W-1:0] growth;
	} gate_settings_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [IN_W-1:0]     s_axis_tdata  = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [OUT_W-1:0]    m_axis_tdata;
	logic                cfg_we        = 1'b0;
	logic [IDX_W-1:0]    cfg_index     = '0;
	logic [COEFF_W-1:0]  cfg_data      = '0;

	// register copies as the gate holds them
	logic [COEFF_W-1:0]  cfg_rise      = RST_ATTACK;
	logic [COEFF_W-1:0]  cfg_fall      = RST_RELEASE;
	logic [COEFF_W-1:0]  cfg_thresh    = RST_THRESHOLD;
	logic [COEFF_W-1:0]  cfg_floor     = RST_FLOOR;
	logic [COEFF_W-1:0]  cfg_close     = RST_CLOSE;
	logic [HOLD_W-1:0]   cfg_hold_base = RST_HOLD_BASE;
	logic [HOLD_W-1:0]   cfg_hold_max  = RST_HOLD_MAX;
	logic [GROW_W-1:0]   cfg_growth    = RST_GROWTH;

	// predicted gate state
	logic [COEFF_W-1:0]  env_level  = '0;
	logic [COEFF_W-1:0]  gain_now   = '0;
	gate_mode_t          mode_now   = MODE_IDLE;
	logic [HOLD_W-1:0]   hold_left  = '0;
	logic [ACT_W-1:0]    active_run = '0;

	key_frame_t          pending_frames[$];    // frames not yet offered
	gated_frame_t        expected_results[$];  // predictions awaiting their transfer
	gated_frame_t        seen_result;
	gated_frame_t        due_result;

	int unsigned         idle_pct        = 0;  // chance of an idle burst, per decision
	int unsigned         feed_gap        = 0;
	int unsigned         drain_gap       = 0;
	int unsigned         backlog_left    = 0;
	bit                  backlog_done    = 1'b0;
	int unsigned         key_xfer_count  = 0;
	int unsigned         quiet_cycles    = 0;
	int unsigned         mismatch_count  = 0;

	hold_gate_with_slewed_gain_unit #(
		.OPEN_COEFF(RISE_COEFF)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------------

	// coefficients and the floor never act above 1.0
	function automatic logic [COEFF_W-1:0] clip_unity(input logic [COEFF_W-1:0] c);
		return (c > ONE_Q24) ? ONE_Q24 : c;
	endfunction

	// level moves by coeff * (target - level) / 2^24, rounded down, kept in [0, 1.0]
	function automatic logic [COEFF_W-1:0] slew_toward(input logic [COEFF_W-1:0] level,
			input logic [COEFF_W-1:0] target, input logic [COEFF_W-1:0] coeff);
		longint delta;
		longint moved;
		delta = (longint'(coeff) * (longint'(target) - longint'(level))) >>> FRAC_W;
		moved = longint'(level) + delta;
		if (moved < 0)
			moved = 0;
		if (moved > longint'(ONE_Q24))
			moved = longint'(ONE_Q24);
		return moved[COEFF_W-1:0];
	endfunction

	// advances the predicted gate by one frame and returns its output transfer
	function automatic gated_frame_t predict_gate(input key_frame_t f);
		gated_frame_t       r;
		longint             dl;
		longint             dr;
		longint             eff_hold;
		logic [COEFF_W-1:0] mag;
		logic [COEFF_W-1:0] coeff;
		logic [COEFF_W-1:0] target;
		logic [HOLD_W-1:0]  base;
		logic [HOLD_W-1:0]  hmax;
		logic               present;

		dl = f.dry_left;
		dr = f.dry_right;
		// zero base acts as one, a maximum below the base acts as the base
		base = (cfg_hold_base == '0) ? HOLD_W'(1) : cfg_hold_base;
		hmax = (cfg_hold_max < base) ? base : cfg_hold_max;

		// peak envelope of the key pair
		mag = COEFF_W'((dl < 0 ? -dl : dl) + (dr < 0 ? -dr : dr));
		coeff = clip_unity((mag > env_level) ? cfg_rise : cfg_fall);
		env_level = slew_toward(env_level, mag, coeff);
		present = env_level > cfg_thresh;

		// active run saturates at 16 times the maximum hold
		if (present && longint'(active_run) < 16 * longint'(hmax))
			active_run = active_run + 1'b1;
		eff_hold = longint'(base) +
			((longint'(cfg_growth) * longint'(active_run)) >>> GROW_W);
		if (eff_hold > longint'(hmax))
			eff_hold = longint'(hmax);

		case (mode_now)
			MODE_IDLE, MODE_CLOSING: begin
				if (present) begin
					mode_now = MODE_OPEN;
					active_run = ACT_W'(1);
				end
			end
			MODE_OPEN: begin
				if (!present) begin
					mode_now = MODE_HOLD;
					hold_left = eff_hold[HOLD_W-1:0];
				end
			end
			default: begin
				if (present) begin
					mode_now = MODE_OPEN;
				end else begin
					if (hold_left != '0)
						hold_left = hold_left - 1'b1;
					if (hold_left == '0)
						mode_now = MODE_CLOSING;
				end
			end
		endcase

		// gain rises at the fixed open rate, falls at the close rate
		target = (mode_now == MODE_OPEN || mode_now == MODE_HOLD) ? ONE_Q24 :
			clip_unity(cfg_floor);
		coeff = (target > gain_now) ? clip_unity(COEFF_W'(RISE_COEFF)) : clip_unity(cfg_close);
		gain_now = slew_toward(gain_now, target, coeff);

		r.left   = SAMPLE_W'((longint'(f.wet_left) * longint'(gain_now)) >>> FRAC_W);
		r.right  = SAMPLE_W'((longint'(f.wet_right) * longint'(gain_now)) >>> FRAC_W);
		r.gain   = gain_now;
		r.status = mode_now;
		r.pad    = '0;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// input side: offers queued frames, predicts each one at its transfer
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			feed_gap <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_results.push_back(predict_gate(key_frame_t'(s_axis_tdata)));
				key_xfer_count <= key_xfer_count + 1;
			end
			// a frame on offer stays put until taken
			if (!s_axis_tvalid || s_axis_tready) begin
				if (feed_gap != 0) begin
					feed_gap <= feed_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_frames.size() != 0 && idle_pct != 0 &&
						$urandom_range(0, 99) < idle_pct) begin
					// idle burst, its remaining length drawn into feed_gap
					feed_gap <= $urandom_range(0, 2);
					s_axis_tvalid <= 1'b0;
				end else if (pending_frames.size() != 0) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= pending_frames.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// output side: checks each transfer, throttles ready
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			drain_gap <= 0;
			backlog_left <= 0;
			backlog_done <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no frame waiting: %h", m_axis_tdata);
					mismatch_count++;
				end else begin
					seen_result = gated_frame_t'(m_axis_tdata);
					due_result = expected_results.pop_front();
					if (seen_result.left !== due_result.left) begin
						$error("gated_left: expected %0d, got %0d",
							due_result.left, seen_result.left);
						mismatch_count++;
					end
					if (seen_result.right !== due_result.right) begin
						$error("gated_right: expected %0d, got %0d",
							due_result.right, seen_result.right);
						mismatch_count++;
					end
					if (seen_result.gain !== due_result.gain) begin
						$error("applied_gain: expected %0d, got %0d",
							due_result.gain, seen_result.gain);
						mismatch_count++;
					end
					if (seen_result.status !== due_result.status) begin
						$error("gate_status: expected %0d, got %0d",
							due_result.status, seen_result.status);
						mismatch_count++;
					end
					if (seen_result.pad !== due_result.pad) begin
						$error("tdata padding: expected %0d, got %0d",
							due_result.pad, seen_result.pad);
						mismatch_count++;
					end
				end
			end

			// one long hold-off mid-run so results back up and the input stalls
			if (!backlog_done && key_xfer_count >= STALL_AFTER) begin
				backlog_done <= 1'b1;
				backlog_left <= STALL_CYCLES;
				m_axis_tready <= 1'b0;
			end else if (backlog_left != 0) begin
				backlog_left <= backlog_left - 1;
				m_axis_tready <= 1'b0;
			end else if (drain_gap != 0) begin
				drain_gap <= drain_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				drain_gap <= $urandom_range(0, 2);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// ends the run when no transfer happens for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	// register write driven at the next edge, mirrored into the predictor
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [COEFF_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			REG_ATTACK:    cfg_rise = value;
			REG_RELEASE:   cfg_fall = value;
			REG_THRESHOLD: cfg_thresh = value;
			REG_FLOOR:     cfg_floor = value;
			REG_CLOSE:     cfg_close = value;
			REG_HOLD_BASE: cfg_hold_base = value[HOLD_W-1:0];
			REG_HOLD_MAX:  cfg_hold_max = value[HOLD_W-1:0];
			REG_GROWTH:    cfg_growth = value[GROW_W-1:0];
			default:       ;  // unmapped index, no effect
		endcase
	endtask

	task automatic program_gate(input gate_settings_t s);
		write_reg(REG_ATTACK, s.rise);
		write_reg(REG_RELEASE, s.fall);
		write_reg(REG_THRESHOLD, s.thresh);
		write_reg(REG_FLOOR, s.floor_lvl);
		write_reg(REG_CLOSE, s.close_c);
		write_reg(REG_HOLD_BASE, s.hold_base);
		write_reg(REG_HOLD_MAX, s.hold_max);
		write_reg(REG_GROWTH, s.growth);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// waits until every frame has been offered and every result has come back
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_frames.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_frame(input logic [SAMPLE_W-1:0] dl, input logic [SAMPLE_W-1:0] dr,
			input logic [SAMPLE_W-1:0] wl, input logic [SAMPLE_W-1:0] wr);
		pending_frames.push_back('{wr, wl, dr, dl});
	endtask

	// full-range sample with the extremes and zero mixed in
	function automatic logic [SAMPLE_W-1:0] any_sample();
		case ($urandom_range(0, 15))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return '0;
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// loud key pair, or a faint one within a few hundred lsb of zero
	function automatic key_frame_t keyed_frame(input bit loud);
		key_frame_t f;
		if (loud) begin
			f.dry_left = any_sample();
			f.dry_right = any_sample();
		end else begin
			f.dry_left = SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
			f.dry_right = SAMPLE_W'($urandom_range(0, 511)) - SAMPLE_W'(256);
		end
		f.wet_left = any_sample();
		f.wet_right = any_sample();
		return f;
	endfunction

	// alternating loud and quiet runs so the gate cycles open, hold, closing;
	// about one frame in ten is of random loudness regardless of the run
	task automatic queue_frames(input int unsigned count);
		int unsigned left;
		int unsigned run_len;
		bit          loud;
		left = count;
		loud = 1'b1;
		while (left > 0) begin
			run_len = loud ? $urandom_range(1, 40) : $urandom_range(1, 60);
			if (run_len > left)
				run_len = left;
			repeat (run_len) begin
				if ($urandom_range(0, 9) == 0)
					pending_frames.push_back(keyed_frame(1'($urandom_range(0, 1))));
				else
					pending_frames.push_back(keyed_frame(loud));
			end
			left -= run_len;
			loud = !loud;
		end
	endtask

	function automatic logic [COEFF_W-1:0] pick_coeff();
		case ($urandom_range(0, 5))
			0:       return COEFF_W'($urandom());  // often above one
			1:       return ONE_Q24;
			2:       return '0;
			default: return COEFF_W'($urandom_range(0, ONE_Q24));
		endcase
	endfunction

	// random settings with short holds so the closing state is reached
	function automatic gate_settings_t draw_settings();
		gate_settings_t s;
		s.rise = pick_coeff();
		s.fall = pick_coeff();
		s.floor_lvl = pick_coeff();
		s.close_c = pick_coeff();
		s.thresh = ($urandom_range(0, 3) == 0) ? COEFF_W'($urandom()) :
			COEFF_W'($urandom_range(0, 4000000));
		s.hold_base = COEFF_W'($urandom_range(0, 24));
		// a maximum of one lets the active run reach its cap quickly
		s.hold_max = ($urandom_range(0, 3) == 0) ? COEFF_W'(1) :
			COEFF_W'($urandom_range(0, 48));
		s.growth = COEFF_W'($urandom_range(0, 65535));
		return s;
	endfunction

	task automatic run_phase(input gate_settings_t s, input int unsigned frames,
			input int unsigned gap_pct);
		wait_drained();
		idle_pct = gap_pct;
		program_gate(s);
		queue_frames(frames);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 20;

		// reset settings: extremes of every field, gate opens from idle
		push_frame('0, '0, '0, '0);
		push_frame(S_MAX, S_MAX, S_MAX, S_MAX);
		push_frame(S_MIN, S_MIN, S_MIN, S_MIN);
		push_frame(S_MAX, S_MIN, S_MIN, S_MAX);
		push_frame(S_MIN, S_MAX, S_MAX, S_MIN);
		push_frame('0, '0, S_MAX, S_MIN);
		push_frame(S_MAX, '0, 24'hFFFFFF, 24'h000001);
		push_frame('0, S_MIN, 24'h555555, 24'hAAAAAA);
		push_frame('0, '0, 24'hAAAAAA, 24'h555555);
		push_frame('0, '0, 24'hFFFFFF, 24'h000001);
		wait_drained();

		// coefficients and floor above one, oversized hold values that truncate
		// to a zero base and a zero maximum, growth at full scale; then writes
		// to unmapped indexes that must leave attack and growth alone
		program_gate('{ALL_ONES_25, ONE_Q24, 25'd1000, ALL_ONES_25, ALL_ONES_25,
			HOLD_OVERSIZED, HOLD_OVERSIZED, ALL_ONES_25});
		write_reg(UNMAPPED_IDX_LO, '0);
		write_reg(UNMAPPED_IDX_HI, 25'd1);
		@(posedge clk);
		cfg_we <= 1'b0;

		// envelope tracks |dl|+|dr| exactly here; the threshold sits at 1000
		push_frame(24'd501, -24'sd500, S_MAX, S_MIN);  // just above: present
		push_frame(24'd500, -24'sd500, S_MIN, S_MAX);  // equal: absent, into hold
		push_frame('0, '0, 24'h000001, 24'hFFFFFF);    // hold runs out
		push_frame('0, '0, S_MAX, S_MAX);              // stays closing
		push_frame(S_MAX, S_MAX, S_MIN, S_MIN);        // reopens
		push_frame('0, '0, 24'h123456, 24'hEDCBA9);    // into hold
		push_frame(S_MIN, '0, 24'h7F0F0F, 24'h80F0F0); // retrigger from hold
		push_frame(S_MIN, S_MIN, 24'h333333, 24'hCCCCCC);
		push_frame('0, '0, 24'hFFFFFF, 24'hFFFFFF);
		push_frame('0, '0, S_MIN, S_MAX);
		push_frame('0, '0, '0, '0);
		push_frame(24'hFFFFFF, 24'h000001, S_MAX, S_MIN);

		// all-zero coefficients: envelope and closing gain frozen
		run_phase('{'0, '0, '0, '0, '0, 25'd1, 25'd1, '0}, 60, 10);
		// threshold at full scale is never exceeded; longest holds
		run_phase('{ONE_Q24, ONE_Q24, ONE_Q24, ONE_Q24, '0,
			25'd262143, 25'd262143, 25'd65535}, 60, 30);
		// longest holds with retriggers, fast close
		run_phase('{ONE_Q24, 25'd300000, 25'd2000000, '0, ONE_Q24,
			25'd262143, 25'd262143, 25'd65535}, 100, 0);

		for (int i = 0; i < 5; i++)
			run_phase(draw_settings(), 170, (i % 2 == 0) ? 15 : 35);

		// last part runs without idle cycles on either side
		run_phase(draw_settings(), 150, 0);
		wait_drained();

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
